@@ rtl/bcc_pkg.sv @@
// Shared types, codes and helpers for the button click classifier.
`default_nettype none

package bcc_pkg;

    localparam int NUM_BUTTONS_DEF = 8;
    localparam int IDX_W           = 3;
    localparam int CFG_ADDR_W      = 3;
    localparam int CFG_DATA_W      = 8;

    localparam logic [7:0] HOLD_TOP = 8'hFF;

    // phase codes
    localparam logic [1:0] PH_IDLE     = 2'd0;
    localparam logic [1:0] PH_PRESSED  = 2'd1;
    localparam logic [1:0] PH_RELEASED = 2'd2;
    localparam logic [1:0] PH_WAIT     = 2'd3;

    // previous phase codes
    localparam logic [1:0] PP_NONE  = 2'd0;
    localparam logic [1:0] PP_PRESS = 2'd1;
    localparam logic [1:0] PP_WAIT  = 2'd2;
    localparam logic [1:0] PP_LONG  = 2'd3;

    // trigger codes
    localparam logic [1:0] TR_NONE   = 2'd0;
    localparam logic [1:0] TR_PRESS  = 2'd1;
    localparam logic [1:0] TR_DOUBLE = 2'd2;
    localparam logic [1:0] TR_LONG   = 2'd3;

    // event codes
    localparam logic [2:0] EV_NONE         = 3'd0;
    localparam logic [2:0] EV_RELEASE      = 3'd1;
    localparam logic [2:0] EV_SINGLE       = 3'd2;
    localparam logic [2:0] EV_DOUBLE       = 3'd3;
    localparam logic [2:0] EV_LONG         = 3'd4;
    localparam logic [2:0] EV_LONG_RELEASE = 3'd5;

    // register indexes
    localparam logic [CFG_ADDR_W-1:0] REG_DEBOUNCE     = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_LONG         = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_LONG_REPEAT  = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_DOUBLE_GAP   = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_LONG_ON_REL  = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] REG_DELAYED_SGL  = 3'd5;
    localparam logic [CFG_ADDR_W-1:0] REG_ACTIVE_MASK  = 3'd6;
    localparam logic [CFG_ADDR_W-1:0] REG_EVENT_ENABLE = 3'd7;

    typedef struct packed {
        logic       stable_level;
        logic [7:0] debounce_count;
        logic [1:0] phase;
        logic [1:0] previous_phase;
        logic [1:0] trigger_event;
        logic [7:0] hold_count;
        logic [7:0] repeat_count;
        logic [7:0] gap_count;
    } bcc_entry_t;

    localparam bcc_entry_t ENTRY_RESET = '{
        stable_level:   1'b1,
        debounce_count: 8'd0,
        phase:          PH_IDLE,
        previous_phase: PP_NONE,
        trigger_event:  TR_NONE,
        hold_count:     8'd0,
        repeat_count:   8'd0,
        gap_count:      8'd0
    };

    typedef struct packed {
        logic [7:0] debounce_ticks;
        logic [7:0] long_ticks;
        logic [7:0] long_repeat_ticks;
        logic [7:0] double_gap_ticks;
        logic       long_on_release;
        logic       delayed_single;
        logic [7:0] active_level_mask;
        logic [4:0] event_enable_mask;
    } bcc_cfg_t;

    function automatic logic ev_enabled(input logic [4:0] mask, input logic [2:0] code);
        logic en;
        case (code)
            EV_RELEASE:      en = mask[0];
            EV_SINGLE:       en = mask[1];
            EV_DOUBLE:       en = mask[2];
            EV_LONG:         en = mask[3];
            EV_LONG_RELEASE: en = mask[4];
            default:         en = 1'b0;
        endcase
        return en;
    endfunction

endpackage

`default_nettype wire

@@ rtl/bcc_step.sv @@
// Per-button debounce and press classification update for one tick.
`default_nettype none

module bcc_step
    import bcc_pkg::*;
(
    input  bcc_entry_t cur,
    input  logic       level,
    input  logic       active,
    input  bcc_cfg_t   cfg,
    output bcc_entry_t nxt,
    output logic [2:0] first_event,
    output logic [2:0] second_event
);

    always_comb begin
        bcc_entry_t s;
        logic [2:0] ev_a;
        logic [2:0] ev_b;
        logic       en_a;
        logic       en_b;
        logic [1:0] trig;

        s    = cur;
        ev_a = EV_NONE;
        ev_b = EV_NONE;
        trig = TR_PRESS;

        if (level != s.stable_level) begin
            s.debounce_count = s.debounce_count + 8'd1;
            if (s.debounce_count >= cfg.debounce_ticks) begin
                s.stable_level   = level;
                s.debounce_count = 8'd0;
                if (s.phase == PH_IDLE || s.phase == PH_WAIT) begin
                    s.phase = PH_PRESSED;
                end else if (s.phase == PH_PRESSED) begin
                    s.phase = PH_RELEASED;
                    ev_a    = EV_RELEASE;
                end
            end
        end

        case (s.phase)
            PH_PRESSED: begin
                if (s.stable_level == active) begin
                    s.hold_count = s.hold_count + 8'd1;
                    if (s.hold_count >= cfg.long_ticks) begin
                        if (cfg.long_on_release) begin
                            trig = TR_LONG;
                        end else begin
                            s.repeat_count = s.repeat_count + 8'd1;
                            if (s.repeat_count >= cfg.long_repeat_ticks) begin
                                s.repeat_count = 8'd0;
                                trig           = TR_LONG;
                                ev_b           = EV_LONG;
                            end else if (s.trigger_event == TR_LONG) begin
                                trig = TR_LONG;
                            end
                        end
                        if (s.hold_count == HOLD_TOP) begin
                            s.hold_count = cfg.long_ticks;
                        end
                    end
                    s.trigger_event = trig;
                end
            end
            PH_RELEASED: begin
                if (s.trigger_event == TR_PRESS) begin
                    if (s.gap_count <= cfg.double_gap_ticks && s.previous_phase == PP_WAIT) begin
                        s.trigger_event  = TR_DOUBLE;
                        ev_b             = EV_DOUBLE;
                        s.phase          = PH_IDLE;
                        s.previous_phase = PP_NONE;
                    end else begin
                        s.gap_count  = 8'd0;
                        s.hold_count = 8'd0;
                        if (!cfg.delayed_single) begin
                            ev_b = EV_SINGLE;
                        end
                        s.phase          = PH_WAIT;
                        s.previous_phase = PP_WAIT;
                    end
                end else if (s.trigger_event == TR_LONG) begin
                    ev_b             = cfg.long_on_release ? EV_LONG : EV_LONG_RELEASE;
                    s.hold_count     = 8'd0;
                    s.phase          = PH_IDLE;
                    s.previous_phase = PP_LONG;
                end
            end
            PH_WAIT: begin
                s.gap_count = s.gap_count + 8'd1;
                if (s.gap_count >= cfg.double_gap_ticks) begin
                    s.phase          = PH_IDLE;
                    s.previous_phase = PP_NONE;
                    if (cfg.delayed_single) begin
                        s.gap_count      = 8'd0;
                        ev_b             = EV_SINGLE;
                        s.previous_phase = PP_PRESS;
                    end
                end
            end
            default: begin
            end
        endcase

        en_a = ev_enabled(cfg.event_enable_mask, ev_a);
        en_b = ev_enabled(cfg.event_enable_mask, ev_b);

        nxt          = s;
        first_event  = en_a ? ev_a : (en_b ? ev_b : EV_NONE);
        second_event = (en_a && en_b) ? ev_b : EV_NONE;
    end

endmodule

`default_nettype wire

@@ rtl/button_click_classifier.sv @@
// Button click classifier: per-button state table with read-modify-write update.
// Pipeline: the table read feeds the update stage, and the update feeds the result register.
// Throughput: one tick per cycle while the result is taken; a tick for the button of the most
// recent update takes the forwarded entry instead of the table read data.
// Reset: clears configuration to defaults and the entry valid bits; an unwritten
// entry reads as the idle entry. No clearing pass.
`default_nettype none

module button_click_classifier
    import bcc_pkg::*;
#(
    parameter int NUM_BUTTONS = NUM_BUTTONS_DEF
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [7:0]            s_tdata,   // button_index[2:0], level[3]
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [15:0]                m_tdata    // first_event[2:0], second_event[5:3],
                                                  // latched_event[7:6], press_state[9:8]
);

    localparam int AW = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1;

    bcc_cfg_t cfg_reg;

    bcc_entry_t table_mem [NUM_BUTTONS];
    logic [NUM_BUTTONS-1:0] entry_valid_reg;

    logic             s1_valid_reg;
    logic             s1_inrange_reg;
    logic [IDX_W-1:0] s1_idx_reg;
    logic             s1_level_reg;
    bcc_entry_t       rd_data_reg;
    logic             rd_hit_reg;

    logic             wb_valid_reg;
    logic [AW-1:0]    wb_addr_reg;
    bcc_entry_t       wb_data_reg;

    logic        m_valid_reg;
    logic [2:0]  first_reg;
    logic [2:0]  second_reg;
    logic [1:0]  latched_reg;
    logic [1:0]  state_reg;

    logic             s_accept;
    logic             s1_advance;
    logic [IDX_W-1:0] in_idx;
    logic             in_inrange;
    logic [AW-1:0]    in_addr;
    logic [AW-1:0]    s1_addr;
    bcc_entry_t       cur_entry;
    bcc_entry_t       nxt_entry;
    logic [2:0]       first_next;
    logic [2:0]       second_next;
    logic             s1_write;

    assign in_idx     = s_tdata[IDX_W-1:0];
    assign in_inrange = (int'(in_idx) < NUM_BUTTONS);
    assign in_addr    = AW'(in_idx);
    assign s1_addr    = AW'(s1_idx_reg);

    assign s1_advance = !m_valid_reg || m_tready;
    assign s_tready   = !s1_valid_reg || s1_advance;
    assign s_accept   = s_tvalid && s_tready;
    assign s1_write   = s1_valid_reg && s1_advance && s1_inrange_reg;

    always_comb begin
        if (wb_valid_reg && wb_addr_reg == s1_addr) begin
            cur_entry = wb_data_reg;
        end else if (rd_hit_reg) begin
            cur_entry = rd_data_reg;
        end else begin
            cur_entry = ENTRY_RESET;
        end
    end

    bcc_step u_step (
        .cur          (cur_entry),
        .level        (s1_level_reg),
        .active       (cfg_reg.active_level_mask[s1_idx_reg]),
        .cfg          (cfg_reg),
        .nxt          (nxt_entry),
        .first_event  (first_next),
        .second_event (second_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '{
                debounce_ticks:    8'd2,
                long_ticks:        8'd50,
                long_repeat_ticks: 8'd5,
                double_gap_ticks:  8'd15,
                long_on_release:   1'b0,
                delayed_single:    1'b0,
                active_level_mask: 8'd0,
                event_enable_mask: 5'd31
            };
        end else if (cfg_we) begin
            case (cfg_addr)
                REG_DEBOUNCE:     cfg_reg.debounce_ticks    <= cfg_wdata;
                REG_LONG:         cfg_reg.long_ticks        <= cfg_wdata;
                REG_LONG_REPEAT:  cfg_reg.long_repeat_ticks <= cfg_wdata;
                REG_DOUBLE_GAP:   cfg_reg.double_gap_ticks  <= cfg_wdata;
                REG_LONG_ON_REL:  cfg_reg.long_on_release   <= cfg_wdata[0];
                REG_DELAYED_SGL:  cfg_reg.delayed_single    <= cfg_wdata[0];
                REG_ACTIVE_MASK:  cfg_reg.active_level_mask <= cfg_wdata;
                REG_EVENT_ENABLE: cfg_reg.event_enable_mask <= cfg_wdata[4:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_write) begin
            table_mem[s1_addr] <= nxt_entry;
        end
        if (s_accept) begin
            rd_data_reg <= table_mem[in_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            entry_valid_reg <= '0;
            rd_hit_reg      <= 1'b0;
        end else begin
            if (s1_write) begin
                entry_valid_reg[s1_addr] <= 1'b1;
            end
            if (s_accept) begin
                rd_hit_reg <= entry_valid_reg[in_addr];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (s_tready) begin
            s1_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            s1_idx_reg     <= in_idx;
            s1_level_reg   <= s_tdata[IDX_W];
            s1_inrange_reg <= in_inrange;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wb_valid_reg <= 1'b0;
        end else if (s1_write) begin
            wb_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_write) begin
            wb_addr_reg <= s1_addr;
            wb_data_reg <= nxt_entry;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s1_advance) begin
            m_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_valid_reg && s1_advance) begin
            if (s1_inrange_reg) begin
                first_reg   <= first_next;
                second_reg  <= second_next;
                latched_reg <= nxt_entry.trigger_event;
                state_reg   <= nxt_entry.phase;
            end else begin
                first_reg   <= EV_NONE;
                second_reg  <= EV_NONE;
                latched_reg <= TR_NONE;
                state_reg   <= PH_IDLE;
            end
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {6'd0, state_reg, latched_reg, second_reg, first_reg};

    a_second_needs_first: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (first_reg != EV_NONE || second_reg == EV_NONE))
        else $error("second event reported without a first event");

    a_event_code_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (first_reg <= EV_LONG_RELEASE && second_reg <= EV_LONG_RELEASE))
        else $error("event code out of range");

    a_stage_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (s1_valid_reg && !s1_advance) |=> (s1_valid_reg && $stable(s1_idx_reg)))
        else $error("update stage lost a request while stalled");

    a_reset_clears_output: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

endmodule

`default_nettype wire

@@ bench/click_event_checker.sv @@
// Checker for the button click classifier: watches all channels, predicts and compares.
`timescale 1ns / 100ps

module click_event_checker
    import bcc_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
    input  wire logic                  s_tvalid,
    input  wire logic                  s_tready,
    input  wire logic [7:0]            s_tdata,   // button_index[2:0], level[3]
    input  wire logic                  m_tvalid,
    input  wire logic                  m_tready,
    input  wire logic [15:0]           m_tdata,   // first_event[2:0], second_event[5:3],
                                                  // latched_event[7:6], press_state[9:8]
    output int                         error_count,
    output int                         outstanding
);

    typedef struct packed {
        logic [1:0] press_state;
        logic [1:0] latched_event;
        logic [2:0] second_event;
        logic [2:0] first_event;
    } click_report_t;

    bcc_cfg_t      cfg;
    logic          stable_lvl [8];
    logic [7:0]    bounce_cnt [8];
    logic [1:0]    phase_st   [8];
    logic [1:0]    prev_phase [8];
    logic [1:0]    trigger    [8];
    logic [7:0]    hold_cnt   [8];
    logic [7:0]    repeat_cnt [8];
    logic [7:0]    gap_cnt    [8];
    logic [2:0]    ev_slot    [2];
    int            ev_used;
    int            mismatches = 0;
    click_report_t report_q [$];

    function automatic void post_event(input logic [2:0] code);
        if (cfg.event_enable_mask[code - 3'd1] && ev_used < 2) begin
            ev_slot[ev_used] = code;
            ev_used++;
        end
    endfunction

    function automatic click_report_t classify_tick(input logic [2:0] b, input logic lvl);
        click_report_t r;
        logic          active;
        logic [1:0]    trig_next;
        ev_used = 0;
        ev_slot[0] = EV_NONE;
        ev_slot[1] = EV_NONE;
        active = cfg.active_level_mask[b];

        // the bounce count keeps its value when the level goes back
        if (lvl != stable_lvl[b]) begin
            bounce_cnt[b] = bounce_cnt[b] + 8'd1;
            if (bounce_cnt[b] >= cfg.debounce_ticks) begin
                stable_lvl[b] = lvl;
                bounce_cnt[b] = 8'd0;
                if (phase_st[b] == PH_IDLE || phase_st[b] == PH_WAIT) begin
                    phase_st[b] = PH_PRESSED;
                end else if (phase_st[b] == PH_PRESSED) begin
                    phase_st[b] = PH_RELEASED;
                    post_event(EV_RELEASE);
                end
            end
        end

        case (phase_st[b])
            PH_PRESSED: begin
                if (stable_lvl[b] == active) begin
                    trig_next = TR_PRESS;
                    hold_cnt[b] = hold_cnt[b] + 8'd1;
                    if (hold_cnt[b] >= cfg.long_ticks) begin
                        if (cfg.long_on_release) begin
                            trig_next = TR_LONG;
                        end else begin
                            repeat_cnt[b] = repeat_cnt[b] + 8'd1;
                            if (repeat_cnt[b] >= cfg.long_repeat_ticks) begin
                                repeat_cnt[b] = 8'd0;
                                trig_next = TR_LONG;
                                post_event(EV_LONG);
                            end else if (trigger[b] == TR_LONG) begin
                                trig_next = TR_LONG;
                            end
                        end
                        if (hold_cnt[b] == HOLD_TOP) begin
                            hold_cnt[b] = cfg.long_ticks;
                        end
                    end
                    trigger[b] = trig_next;
                end
            end
            PH_RELEASED: begin
                if (trigger[b] == TR_PRESS) begin
                    if (gap_cnt[b] <= cfg.double_gap_ticks && prev_phase[b] == PP_WAIT) begin
                        trigger[b] = TR_DOUBLE;
                        post_event(EV_DOUBLE);
                        phase_st[b] = PH_IDLE;
                        prev_phase[b] = PP_NONE;
                    end else begin
                        gap_cnt[b] = 8'd0;
                        hold_cnt[b] = 8'd0;
                        if (!cfg.delayed_single) begin
                            post_event(EV_SINGLE);
                        end
                        phase_st[b] = PH_WAIT;
                        prev_phase[b] = PP_WAIT;
                    end
                end else if (trigger[b] == TR_LONG) begin
                    post_event(cfg.long_on_release ? EV_LONG : EV_LONG_RELEASE);
                    hold_cnt[b] = 8'd0;
                    phase_st[b] = PH_IDLE;
                    prev_phase[b] = PP_LONG;
                end
            end
            PH_WAIT: begin
                gap_cnt[b] = gap_cnt[b] + 8'd1;
                if (gap_cnt[b] >= cfg.double_gap_ticks) begin
                    phase_st[b] = PH_IDLE;
                    prev_phase[b] = PP_NONE;
                    if (cfg.delayed_single) begin
                        gap_cnt[b] = 8'd0;
                        post_event(EV_SINGLE);
                        prev_phase[b] = PP_PRESS;
                    end
                end
            end
            default: begin
            end
        endcase

        r.first_event   = ev_slot[0];
        r.second_event  = ev_slot[1];
        r.latched_event = trigger[b];
        r.press_state   = phase_st[b];
        return r;
    endfunction

    task automatic note_mismatch(input string what, input click_report_t want,
                                 input click_report_t seen);
        mismatches++;
        if (mismatches <= 10) begin
            $display("%0t: %s: expected first %0d second %0d latched %0d state %0d", $time,
                     what, want.first_event, want.second_event, want.latched_event,
                     want.press_state);
            $display("    actual first %0d second %0d latched %0d state %0d",
                     seen.first_event, seen.second_event, seen.latched_event,
                     seen.press_state);
        end
    endtask

    always @(posedge aclk) begin : monitor
        click_report_t seen;
        click_report_t want;
        if (!aresetn) begin
            cfg.debounce_ticks    = 8'd2;
            cfg.long_ticks        = 8'd50;
            cfg.long_repeat_ticks = 8'd5;
            cfg.double_gap_ticks  = 8'd15;
            cfg.long_on_release   = 1'b0;
            cfg.delayed_single    = 1'b0;
            cfg.active_level_mask = 8'h00;
            cfg.event_enable_mask = 5'h1F;
            for (int b = 0; b < 8; b++) begin
                stable_lvl[b] = ~cfg.active_level_mask[b];
                bounce_cnt[b] = 8'd0;
                phase_st[b]   = PH_IDLE;
                prev_phase[b] = PP_NONE;
                trigger[b]    = TR_NONE;
                hold_cnt[b]   = 8'd0;
                repeat_cnt[b] = 8'd0;
                gap_cnt[b]    = 8'd0;
            end
            report_q.delete();
        end else begin
            if (cfg_we) begin
                case (cfg_addr)
                    REG_DEBOUNCE:     cfg.debounce_ticks    = cfg_wdata;
                    REG_LONG:         cfg.long_ticks        = cfg_wdata;
                    REG_LONG_REPEAT:  cfg.long_repeat_ticks = cfg_wdata;
                    REG_DOUBLE_GAP:   cfg.double_gap_ticks  = cfg_wdata;
                    REG_LONG_ON_REL:  cfg.long_on_release   = cfg_wdata[0];
                    REG_DELAYED_SGL:  cfg.delayed_single    = cfg_wdata[0];
                    REG_ACTIVE_MASK:  cfg.active_level_mask = cfg_wdata;
                    REG_EVENT_ENABLE: cfg.event_enable_mask = cfg_wdata[4:0];
                    default: begin
                    end
                endcase
            end
            if (s_tvalid && s_tready) begin
                report_q.push_back(classify_tick(s_tdata[2:0], s_tdata[3]));
            end
            if (m_tvalid && m_tready) begin
                seen = m_tdata[9:0];
                if (report_q.size() == 0) begin
                    note_mismatch("result with no pending request", '0, seen);
                end else begin
                    want = report_q.pop_front();
                    if (seen !== want) begin
                        note_mismatch("click result mismatch", want, seen);
                    end
                end
            end
        end
        outstanding <= report_q.size();
        error_count <= mismatches;
    end

endmodule

@@ bench/testbench.sv @@
// Top of the button click classifier bench: clock, reset, tick stimulus and verdict.
`timescale 1ns / 100ps

module testbench;
    import bcc_pkg::*;

    localparam int LATENCY_WAIT = 8;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int TICK_CAP     = 300;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr  = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [7:0]            s_tdata   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [15:0]           m_tdata;

    int       error_count;
    int       outstanding;
    int       send_idle_pct = 10;
    int       recv_idle_pct = 85;
    int       items_sent    = 0;
    int       items_stop    = 0;
    int       cycle_count   = 0;
    bcc_cfg_t cur_cfg;

    button_click_classifier i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    click_event_checker i_checker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_we      (cfg_we),
        .cfg_addr    (cfg_addr),
        .cfg_wdata   (cfg_wdata),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .error_count (error_count),
        .outstanding (outstanding)
    );

    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    task automatic send_tick(input logic [2:0] b, input logic lvl);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {4'b0000, lvl, b};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        items_sent++;
    endtask

    task automatic wait_idle;
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
        repeat (LATENCY_WAIT) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] addr,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_addr  <= addr;
        cfg_wdata <= data;
        @(posedge aclk);
    endtask

    task automatic apply_setting(input bcc_cfg_t c);
        wait_idle();
        write_reg(REG_DEBOUNCE,     c.debounce_ticks);
        write_reg(REG_LONG,         c.long_ticks);
        write_reg(REG_LONG_REPEAT,  c.long_repeat_ticks);
        write_reg(REG_DOUBLE_GAP,   c.double_gap_ticks);
        write_reg(REG_LONG_ON_REL,  {7'd0, c.long_on_release});
        write_reg(REG_DELAYED_SGL,  {7'd0, c.delayed_single});
        write_reg(REG_ACTIVE_MASK,  c.active_level_mask);
        write_reg(REG_EVENT_ENABLE, {3'd0, c.event_enable_mask});
        cfg_we <= 1'b0;
        cur_cfg = c;
    endtask

    function automatic bcc_cfg_t phase_setting(input int s);
        bcc_cfg_t c;
        case (s)
            0: c = '{8'd1,   8'd8,   8'd3,   8'd6,   1'b0, 1'b0, 8'h00, 5'h1F};
            1: c = '{8'd2,   8'd12,  8'd1,   8'd10,  1'b1, 1'b0, 8'h00, 5'h1F};
            2: c = '{8'd3,   8'd20,  8'd4,   8'd255, 1'b0, 1'b1, 8'h00,
                     5'($urandom_range(1, 30))};
            3: c = '{8'd1,   8'd1,   8'd255, 8'd1,   1'b0, 1'b1, 8'h00, 5'h00};
            4: c = '{8'd255, 8'd254, 8'd255, 8'd255, 1'b1, 1'b1, 8'h00, 5'h1F};
            5: c = '{8'd2,   8'd10,  8'd2,   8'd8,   1'b0, 1'b0, 8'hFF, 5'h1F};
            default: c = '{8'd4, 8'd30, 8'd6, 8'd20, 1'b1, 1'b1, 8'hA5, 5'h15};
        endcase
        return c;
    endfunction

    // hold a button at one level, with rare bounce and stray ticks on random buttons
    task automatic drive_level(input logic [2:0] b, input logic lvl, input int n);
        logic [2:0] other;
        if (n > TICK_CAP) n = TICK_CAP;
        for (int k = 0; k < n && items_sent < items_stop; k++) begin
            if ($urandom_range(99) < 8) begin
                other = 3'($urandom_range(7));
                send_tick(other, ~cur_cfg.active_level_mask[other]);
            end
            send_tick(b, ($urandom_range(99) < 4) ? ~lvl : lvl);
        end
    endtask

    task automatic run_gestures(input int budget);
        int         kind;
        int         deb;
        int         gap;
        logic [2:0] b;
        logic       pl;
        items_stop = items_sent + budget;
        while (items_sent < items_stop) begin
            b    = 3'($urandom_range(7));
            pl   = cur_cfg.active_level_mask[b];
            deb  = cur_cfg.debounce_ticks;
            gap  = cur_cfg.double_gap_ticks;
            kind = $urandom_range(99);
            if (kind < 30) begin
                drive_level(b, pl, deb + $urandom_range(0, 3));
                drive_level(b, ~pl, deb + $urandom_range(0, 3));
            end else if (kind < 55) begin
                drive_level(b, pl, deb + $urandom_range(0, 2));
                drive_level(b, ~pl, deb + $urandom_range(0, 2));
                drive_level(b, pl, deb + $urandom_range(0, 2));
                drive_level(b, ~pl, deb + gap + 2);
            end else if (kind < 75) begin
                drive_level(b, pl, deb + int'(cur_cfg.long_ticks) +
                            $urandom_range(0, 2 * int'(cur_cfg.long_repeat_ticks)));
                drive_level(b, ~pl, deb + 2);
            end else if (kind < 85) begin
                drive_level(b, ~pl, gap + 2);
            end else begin
                repeat ($urandom_range(1, 8)) begin
                    send_tick(3'($urandom_range(7)), 1'($urandom_range(1)));
                end
            end
        end
    endtask

    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        apply_setting('{8'd1, 8'd2, 8'd1, 8'd3, 1'b0, 1'b0, 8'h00, 5'h1F});
        // long press with repeats, then long release
        send_tick(3'd0, 1'b0);
        send_tick(3'd0, 1'b0);
        send_tick(3'd0, 1'b0);
        send_tick(3'd0, 1'b1);
        // single click, then double click inside the window
        send_tick(3'd7, 1'b0);
        send_tick(3'd7, 1'b1);
        send_tick(3'd7, 1'b0);
        send_tick(3'd7, 1'b1);
        send_tick(3'd7, 1'b1);
        send_tick(3'd7, 1'b1);
        // single click left to expire the window
        send_tick(3'd2, 1'b0);
        send_tick(3'd2, 1'b1);
        send_tick(3'd2, 1'b1);
        send_tick(3'd2, 1'b1);
        send_tick(3'd2, 1'b1);
        send_tick(3'd3, 1'b1);
        send_tick(3'd4, 1'b1);

        for (int s = 0; s < 7; s++) begin
            apply_setting(phase_setting(s));
            if (s < 2) begin
                send_idle_pct = 10;
                recv_idle_pct = 85;
            end else if (s < 4) begin
                send_idle_pct = 85;
                recv_idle_pct = 10;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            run_gestures(240);
        end

        wait_idle();
        if (error_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
